// ===== hw/rtl/pgfe_pkg.sv =====
`default_nettype none

package pgfe_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int MAX_SAMPLES = 16384;
    localparam int INDEX_W     = 15;
    localparam int PEAK_W      = 14;
    localparam int CFG_W       = 15;
    localparam int CFG_INDEX_W = 1;
    localparam int SUM_W       = 32;
    localparam int SQSUM_W     = 45;
    localparam int AREA_W      = 30;
    localparam int PED_W       = 24;
    localparam int NOISE_W     = 24;
    localparam int MAXV_W      = 15;

    localparam int MAG_W  = 30;
    localparam int MUL_W  = 30;
    localparam int ACC_W  = 2 * MUL_W;
    localparam int DIV_W  = 28;
    localparam int REM_W  = 32;
    localparam int CSU_W  = REM_W + 2;
    localparam int DQ_W   = 62;
    localparam int ROOT_W = DQ_W / 2;
    localparam int CNT_W  = 6;

    localparam int MUL_STEPS  = 5;
    localparam int PED_STEPS  = MAG_W + 8;
    localparam int NDIV_STEPS = DQ_W;
    localparam int SQRT_STEPS = ROOT_W;

    localparam int P_MIN          = 2;
    localparam int PREPULSE_RESET = 100;
    localparam int AREA_RESET     = 70;

    localparam logic [CFG_INDEX_W-1:0] REG_PREPULSE_TICKS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_AREA_WINDOW    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PED,
        ST_NDIV,
        ST_SQRT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pgfe_ifs.sv =====
`default_nettype none

interface pgfe_sample_if;
    import pgfe_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_sample;

    modport source (output valid, sample, last_sample, input ready);
    modport sink (input valid, sample, last_sample, output ready);
endinterface

interface pgfe_result_if;
    import pgfe_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [PED_W-1:0]    pedestal_q8;
    logic [NOISE_W-1:0]         noise_q8;
    logic [MAXV_W-1:0]          max_value;
    logic signed [SAMPLE_W-1:0] min_value;
    logic [PEAK_W-1:0]          peak_time;
    logic signed [AREA_W-1:0]   area;
    logic                       short_waveform;

    modport source (output valid, pedestal_q8, noise_q8, max_value, min_value, peak_time,
                    area, short_waveform, input ready);
    modport sink (input valid, pedestal_q8, noise_q8, max_value, min_value, peak_time,
                  area, short_waveform, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/pulse_gain_feature_extractor.sv =====
`default_nettype none
// Samples that do not close a waveform are taken one per cycle and folded in at once.
// The closing sample keeps the block busy for five multiplier steps, then
// 38 pedestal and 62 noise divider steps and 31 square root steps on one compare-subtract
// unit; the result is registered when the output slot is free, and ready returns
// in that cycle. Reset is asynchronous and active low; it restores the register defaults
// and clears the waveform sums.

module pulse_gain_feature_extractor (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [pgfe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [pgfe_pkg::CFG_W-1:0]       cfg_data,
    pgfe_sample_if.sink                           samples,
    pgfe_result_if.source                         results
);
    import pgfe_pkg::*;

    state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CFG_W-1:0] ticks_reg, ticks_next;
    logic [CFG_W-1:0] window_reg, window_next;

    logic [INDEX_W-1:0]         idx_reg, idx_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [SQSUM_W-1:0]         sqsum_reg, sqsum_next;
    logic signed [AREA_W-1:0]   area_reg, area_next;
    logic [MAXV_W-1:0]          max_reg, max_next;
    logic signed [SAMPLE_W-1:0] min_reg, min_next;
    logic [PEAK_W-1:0]          peak_reg, peak_next;

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]  prod_reg, prod_next;
    logic [DIV_W-1:0]  div_reg, div_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [DQ_W-1:0]   dq_reg, dq_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [PED_W-1:0]  ped_reg, ped_next;

    logic                       res_valid_reg, res_valid_next;
    logic [PED_W-1:0]           res_ped_reg, res_ped_next;
    logic [NOISE_W-1:0]         res_noise_reg, res_noise_next;
    logic [MAXV_W-1:0]          res_max_reg, res_max_next;
    logic signed [SAMPLE_W-1:0] res_min_reg, res_min_next;
    logic [PEAK_W-1:0]          res_peak_reg, res_peak_next;
    logic signed [AREA_W-1:0]   res_area_reg, res_area_next;
    logic                       res_short_reg, res_short_next;

    logic [CFG_W-1:0]             p_eff;
    logic                         in_accept;
    logic signed [SAMPLE_W-1:0]   v;
    logic signed [2*SAMPLE_W-1:0] v_sq;
    logic [SUM_W-1:0]             sum_abs;
    logic [MAG_W-1:0]             mag;
    logic [MUL_W-1:0]             mul_a, mul_b;
    logic [ACC_W-1:0]             mul_p;
    logic                         add_sub;
    logic [ACC_W-1:0]             add_b;
    logic [ACC_W:0]               add_s;
    logic [CSU_W-1:0]             csu_a, csu_b;
    logic [CSU_W:0]               csu_d;
    logic                         csu_ge;
    logic [REM_W-1:0]             rem_step;
    logic [DQ_W-1:0]              div_shift;
    logic [PED_W-1:0]             ped_q;
    logic                         res_free;

    always_comb
    begin
        if (ticks_reg < CFG_W'(P_MIN))
        begin
            p_eff = CFG_W'(P_MIN);
        end
        else if (ticks_reg > CFG_W'(MAX_SAMPLES))
        begin
            p_eff = CFG_W'(MAX_SAMPLES);
        end
        else
        begin
            p_eff = ticks_reg;
        end
    end

    assign samples.ready = (state_reg == ST_IDLE);
    assign in_accept     = samples.valid && samples.ready;
    assign v             = samples.sample;
    assign v_sq          = v * v;

    assign sum_abs = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign mag     = sum_abs[MAG_W-1:0];

    always_comb
    begin
        case (cnt_reg)
            CNT_W'(0):
            begin
                mul_a = MUL_W'(p_eff);
                mul_b = sqsum_reg[MUL_W-1:0];
            end
            CNT_W'(1):
            begin
                mul_a = MUL_W'(p_eff);
                mul_b = MUL_W'(sqsum_reg[SQSUM_W-1:MUL_W]);
            end
            CNT_W'(2):
            begin
                mul_a = mag;
                mul_b = mag;
            end
            CNT_W'(3):
            begin
                mul_a = MUL_W'(p_eff);
                mul_b = MUL_W'(p_eff - 1'b1);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    assign add_sub = (cnt_reg == CNT_W'(3));
    assign add_b   = add_sub ? ~prod_reg : {prod_reg[ACC_W-MUL_W-1:0], {MUL_W{1'b0}}};
    assign add_s   = {1'b0, acc_reg} + {1'b0, add_b} + (ACC_W + 1)'(add_sub);

    always_comb
    begin
        if (state_reg == ST_SQRT)
        begin
            csu_a = {rem_reg, dq_reg[DQ_W-1 -: 2]};
            csu_b = {1'b0, root_reg, 2'b01};
        end
        else if (state_reg == ST_NDIV)
        begin
            csu_a = {1'b0, rem_reg, dq_reg[DQ_W-1]};
            csu_b = CSU_W'(div_reg);
        end
        else
        begin
            csu_a = {1'b0, rem_reg, dq_reg[DQ_W-1]};
            csu_b = CSU_W'(p_eff);
        end
    end

    assign csu_d     = {1'b0, csu_a} - {1'b0, csu_b};
    assign csu_ge    = !csu_d[CSU_W];
    assign rem_step  = csu_ge ? csu_d[REM_W-1:0] : csu_a[REM_W-1:0];
    assign div_shift = {dq_reg[DQ_W-2:0], csu_ge};
    assign ped_q     = div_shift[PED_W-1:0];
    assign res_free  = !res_valid_reg || results.ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ticks_next     = ticks_reg;
        window_next    = window_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        sqsum_next     = sqsum_reg;
        area_next      = area_reg;
        max_next       = max_reg;
        min_next       = min_reg;
        peak_next      = peak_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        root_next      = root_reg;
        ped_next       = ped_reg;
        res_valid_next = res_valid_reg && !results.ready;
        res_ped_next   = res_ped_reg;
        res_noise_next = res_noise_reg;
        res_max_next   = res_max_reg;
        res_min_next   = res_min_reg;
        res_peak_next  = res_peak_reg;
        res_area_next  = res_area_reg;
        res_short_next = res_short_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_PREPULSE_TICKS: ticks_next  = cfg_data;
                REG_AREA_WINDOW:    window_next = cfg_data;
                default:            ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (idx_reg < INDEX_W'(MAX_SAMPLES))
                    begin
                        if (idx_reg < p_eff)
                        begin
                            sum_next   = sum_reg + SUM_W'(v);
                            sqsum_next = sqsum_reg + SQSUM_W'(unsigned'(v_sq));
                        end
                        if (v > $signed({1'b0, max_reg}))
                        begin
                            max_next  = v[MAXV_W-1:0];
                            peak_next = idx_reg[PEAK_W-1:0];
                        end
                        if (idx_reg < window_reg)
                        begin
                            area_next = area_reg + AREA_W'(v);
                        end
                        if (v < min_reg)
                        begin
                            min_next = v;
                        end
                        idx_next = idx_reg + 1'b1;
                    end
                    if (samples.last_sample)
                    begin
                        state_next = ST_MUL;
                        cnt_next   = '0;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next = mul_p;
                cnt_next  = cnt_reg + 1'b1;
                case (cnt_reg)
                    CNT_W'(1): acc_next = prod_reg;
                    CNT_W'(2): acc_next = add_s[ACC_W-1:0];
                    CNT_W'(3): acc_next = add_s[ACC_W] ? add_s[ACC_W-1:0] : '0;
                    default:   ;
                endcase
                if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                begin
                    div_next   = prod_reg[DIV_W-1:0];
                    rem_next   = '0;
                    dq_next    = {mag, 8'b0, {(DQ_W - PED_STEPS){1'b0}}};
                    cnt_next   = '0;
                    state_next = ST_PED;
                end
            end
            ST_PED:
            begin
                rem_next = rem_step;
                dq_next  = div_shift;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(PED_STEPS - 1))
                begin
                    if (sum_reg[SUM_W-1])
                    begin
                        ped_next = (rem_step != '0) ? ~ped_q : (~ped_q + 1'b1);
                    end
                    else
                    begin
                        ped_next = ped_q;
                    end
                    rem_next   = REM_W'(acc_reg[ACC_W-1:DQ_W-16]);
                    dq_next    = {acc_reg[DQ_W-17:0], 16'b0};
                    cnt_next   = '0;
                    state_next = ST_NDIV;
                end
            end
            ST_NDIV:
            begin
                rem_next = rem_step;
                dq_next  = div_shift;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NDIV_STEPS - 1))
                begin
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = '0;
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                rem_next  = rem_step;
                root_next = {root_reg[ROOT_W-2:0], csu_ge};
                dq_next   = {dq_reg[DQ_W-3:0], 2'b00};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQRT_STEPS - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    res_ped_next   = ped_reg;
                    res_noise_next = (|root_reg[ROOT_W-1:NOISE_W]) ? '1 : root_reg[NOISE_W-1:0];
                    res_max_next   = max_reg;
                    res_min_next   = min_reg;
                    res_peak_next  = peak_reg;
                    res_area_next  = area_reg;
                    res_short_next = (idx_reg < p_eff);
                    idx_next       = '0;
                    sum_next       = '0;
                    sqsum_next     = '0;
                    area_next      = '0;
                    max_next       = '0;
                    min_next       = '0;
                    peak_next      = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ticks_reg     <= CFG_W'(PREPULSE_RESET);
            window_reg    <= CFG_W'(AREA_RESET);
            idx_reg       <= '0;
            sum_reg       <= '0;
            sqsum_reg     <= '0;
            area_reg      <= '0;
            max_reg       <= '0;
            min_reg       <= '0;
            peak_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ticks_reg     <= ticks_next;
            window_reg    <= window_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            sqsum_reg     <= sqsum_next;
            area_reg      <= area_next;
            max_reg       <= max_next;
            min_reg       <= min_next;
            peak_reg      <= peak_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        prod_reg      <= prod_next;
        div_reg       <= div_next;
        rem_reg       <= rem_next;
        dq_reg        <= dq_next;
        root_reg      <= root_next;
        ped_reg       <= ped_next;
        res_ped_reg   <= res_ped_next;
        res_noise_reg <= res_noise_next;
        res_max_reg   <= res_max_next;
        res_min_reg   <= res_min_next;
        res_peak_reg  <= res_peak_next;
        res_area_reg  <= res_area_next;
        res_short_reg <= res_short_next;
    end

    assign results.valid          = res_valid_reg;
    assign results.pedestal_q8    = res_ped_reg;
    assign results.noise_q8       = res_noise_reg;
    assign results.max_value      = res_max_reg;
    assign results.min_value      = res_min_reg;
    assign results.peak_time      = res_peak_reg;
    assign results.area           = res_area_reg;
    assign results.short_waveform = res_short_reg;

`ifndef ASSERT_OFF
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg) == ST_DONE)
        else $error("A result item appeared without a finished calculation.");

    a_last_starts_calc: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && samples.last_sample) |=> state_reg == ST_MUL)
        else $error("The closing item did not start the calculation.");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= INDEX_W'(MAX_SAMPLES))
        else $error("The sample index passed its limit.");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NDIV) |-> rem_reg < REM_W'(div_reg))
        else $error("The noise divider remainder reached the divisor.");

    a_sqrt_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQRT) |-> rem_reg <= {root_reg, 1'b0})
        else $error("The square root remainder exceeded twice the partial root.");
`endif

endmodule

`default_nettype wire
